### hdl/lbs_pkg.sv
// ============================================================================
// lbs_pkg: shared types and constants for the linear blend skinning block
// Holds the controller state type, the command struct, the fixed field
// widths and a 32-bit saturation helper.
// ============================================================================
package lbs_pkg;

    localparam int MAX_BONES_DEF = 256;
    localparam int COORD_W       = 32;
    localparam int WEIGHT_W      = 16;
    localparam int TEX_W         = 64;
    localparam int CNT_W         = 16;
    localparam int INFL_W        = 3;
    localparam int ADDR_W        = 12;
    localparam int SLOTS         = 16;
    localparam int SLOT_W        = 4;

    localparam logic [0:0] FUNC_WRITE  = 1'b0;
    localparam logic [0:0] FUNC_VERTEX = 1'b1;

    localparam logic [0:0] REG_INFLUENCE = 1'b0;
    localparam logic [0:0] REG_VCOUNT    = 1'b1;

    // Wide enough for one minus three full-scale weights
    localparam logic signed [18:0] ONE_Q15 = 19'sd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_BLEND,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;      // capture the vertex item
        logic       rd_en;     // read one palette word
        logic [1:0] bone;      // bone slot being worked
        logic [3:0] slot;      // matrix slot read this cycle
        logic       mac_en;    // accumulate the word read last cycle
        logic [3:0] mac_slot;  // slot of that word
        logic       bone_end;  // finish the bone: saturate and weight it
        logic       clr;       // clear blend sums
        logic       finish;    // form final results
    } t_cmd;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

### hdl/lbs_datapath.sv
// ============================================================================
// lbs_datapath: palette memory, bone transform and weight blend
// One palette word is read per cycle; a pair of 32x32 multipliers (position
// and normal) feeds six per-coordinate accumulators, then one weight product
// per coordinate.
// ============================================================================
module lbs_datapath #(
    parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
    localparam int BONE_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [11:0]          i_wr_addr,
    input  logic signed [31:0]   i_wr_data,
    input  lbs_pkg::t_cmd        i_cmd,
    input  logic [2:0]           i_mode,      // effective bone count 1..4
    input  logic [31:0]          i_bone_indices,
    input  logic [47:0]          i_weights,
    input  logic signed [31:0]   i_pos [3],
    input  logic signed [31:0]   i_norm [3],
    input  logic [63:0]          i_tex,
    output logic signed [31:0]   o_pos [3],
    output logic signed [31:0]   o_norm [3],
    output logic [63:0]          o_tex
);
    localparam int DEPTH = MAX_BONES * lbs_pkg::SLOTS;
    localparam int MEM_W = BONE_W + lbs_pkg::SLOT_W;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd;
    logic [MEM_W-1:0]   w_rd_addr;
    logic [7:0]         w_bone_idx;
    logic [7:0]         w_bone_sel;
    logic [7:0]         w_bone_mod [256];

    logic [31:0]        r_bones;
    logic [47:0]        r_wts;
    logic signed [31:0] r_v [6];
    logic [63:0]        r_tex;
    logic signed [63:0] r_acc [6];
    logic signed [63:0] r_sum [6];
    logic signed [31:0] r_opos [3];
    logic signed [31:0] r_onorm [3];

    // Fold bone indices into the palette range
    for (genvar b = 0; b < 256; b++) begin : g_bone_mod
        assign w_bone_mod[b] = 8'(b % MAX_BONES);
    end

    // Palette write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en && ({4'd0, i_wr_addr[11:4]} < 12'(MAX_BONES))) begin
            r_mem[i_wr_addr[MEM_W-1:0]] <= i_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        w_bone_idx = r_bones[8*i_cmd.bone +: 8];
        w_bone_sel = w_bone_mod[w_bone_idx];
        w_rd_addr  = {w_bone_sel[BONE_W-1:0], i_cmd.slot};
    end

    // Weight of the current bone slot
    logic signed [18:0] w_wt;
    always_comb begin
        logic signed [18:0] a, b, c;
        a = $signed({3'b0, r_wts[15:0]});
        b = $signed({3'b0, r_wts[31:16]});
        c = $signed({3'b0, r_wts[47:32]});
        w_wt = 19'sd0;
        case (i_mode)
            3'd2: w_wt = (i_cmd.bone == 2'd0) ? lbs_pkg::ONE_Q15 - a : a;
            3'd3: begin
                case (i_cmd.bone)
                    2'd0:    w_wt = a;
                    2'd1:    w_wt = b;
                    default: w_wt = lbs_pkg::ONE_Q15 - a - b;
                endcase
            end
            3'd4: begin
                case (i_cmd.bone)
                    2'd0:    w_wt = a;
                    2'd1:    w_wt = b;
                    2'd2:    w_wt = c;
                    default: w_wt = lbs_pkg::ONE_Q15 - a - b - c;
                endcase
            end
            default: w_wt = 19'sd0;
        endcase
    end

    // One product per cycle: slot r*3+c for rows 0..2, translation for row 3
    logic [1:0]         w_row, w_col;
    logic signed [63:0] w_prod_p, w_prod_n;
    always_comb begin
        case (i_cmd.mac_slot) inside
            [4'd0:4'd2]: begin
                w_row = 2'd0;
                w_col = i_cmd.mac_slot[1:0];
            end
            [4'd3:4'd5]: begin
                w_row = 2'd1;
                w_col = 2'(i_cmd.mac_slot - 4'd3);
            end
            [4'd6:4'd8]: begin
                w_row = 2'd2;
                w_col = 2'(i_cmd.mac_slot - 4'd6);
            end
            default: begin
                w_row = 2'd3;
                w_col = 2'(i_cmd.mac_slot - 4'd9);
            end
        endcase
        w_prod_p = 64'sd0;
        w_prod_n = 64'sd0;
        if (w_row != 2'd3) begin
            w_prod_p = (r_v[w_row] * r_rd) >>> 16;
            w_prod_n = (r_v[3 + w_row] * r_rd) >>> 16;
        end else begin
            w_prod_p = 64'(r_rd);
        end
    end

    // Capture inputs, accumulate, weight and blend
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bones <= i_bone_indices;
            r_wts   <= i_weights;
            r_tex   <= i_tex;
            for (int k = 0; k < 3; k++) begin
                r_v[k]     <= i_pos[k];
                r_v[3 + k] <= i_norm[k];
            end
        end
        if (i_cmd.clr) begin
            for (int k = 0; k < 6; k++) begin
                r_acc[k] <= 64'sd0;
                r_sum[k] <= 64'sd0;
            end
        end else begin
            if (i_cmd.mac_en) begin
                r_acc[w_col]     <= r_acc[w_col] + w_prod_p;
                if (w_row != 2'd3) begin
                    r_acc[3 + w_col] <= r_acc[3 + w_col] + w_prod_n;
                end
            end
            if (i_cmd.bone_end) begin
                for (int k = 0; k < 6; k++) begin
                    if (i_mode == 3'd1) begin
                        r_sum[k] <= 64'(lbs_pkg::sat32(r_acc[k]));
                    end else begin
                        r_sum[k] <= r_sum[k] + lbs_pkg::sat32(r_acc[k]) * w_wt;
                    end
                    r_acc[k] <= 64'sd0;
                end
            end
        end
        if (i_cmd.finish) begin
            for (int k = 0; k < 3; k++) begin
                r_opos[k]  <= (i_mode == 3'd1) ? r_sum[k][31:0]
                              : lbs_pkg::sat32(r_sum[k] >>> 15);
                r_onorm[k] <= (i_mode == 3'd1) ? r_sum[3 + k][31:0]
                              : lbs_pkg::sat32(r_sum[3 + k] >>> 15);
            end
            o_tex <= r_tex;
        end
    end

    assign o_pos  = r_opos;
    assign o_norm = r_onorm;
endmodule

### hdl/lbs_ctrl.sv
// ============================================================================
// lbs_ctrl: sequencer for palette reads and the per-bone transform
// Walks the twelve matrix slots of each bone, then weights it, then blends.
// ============================================================================
module lbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,     // vertex transfer accepted
    input  logic [2:0]    i_mode,
    input  logic          i_out_free,  // result register can be loaded
    output lbs_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done       // results formed this cycle
);
    lbs_pkg::t_state r_state, n_state;
    logic [3:0] r_slot, n_slot;
    logic [1:0] r_bone, n_bone;
    logic       r_mac, n_mac;
    logic [3:0] r_mslot, n_mslot;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbs_pkg::ST_IDLE;
            r_slot  <= '0;
            r_bone  <= '0;
            r_mac   <= 1'b0;
            r_mslot <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_bone  <= n_bone;
            r_mac   <= n_mac;
            r_mslot <= n_mslot;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_bone  = r_bone;
        n_mac   = 1'b0;
        n_mslot = r_slot;
        o_cmd   = '0;
        o_cmd.bone     = r_bone;
        o_cmd.slot     = r_slot;
        o_cmd.mac_en   = r_mac;
        o_cmd.mac_slot = r_mslot;
        o_busy = (r_state != lbs_pkg::ST_IDLE);
        o_done = 1'b0;
        case (r_state)
            lbs_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    o_cmd.clr  = 1'b1;
                    n_slot  = '0;
                    n_bone  = '0;
                    n_state = lbs_pkg::ST_READ;
                end
            end
            lbs_pkg::ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_mac = 1'b1;
                if (r_slot == 4'd11) begin
                    n_state = lbs_pkg::ST_MAC;
                end else begin
                    n_slot = r_slot + 4'd1;
                end
            end
            lbs_pkg::ST_MAC: begin
                n_state = lbs_pkg::ST_BLEND;
            end
            lbs_pkg::ST_BLEND: begin
                o_cmd.bone_end = 1'b1;
                n_slot = '0;
                if (3'({1'b0, r_bone} + 3'd1) >= i_mode) begin
                    n_state = lbs_pkg::ST_OUT;
                end else begin
                    n_bone  = r_bone + 2'd1;
                    n_state = lbs_pkg::ST_READ;
                end
            end
            lbs_pkg::ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    o_done  = 1'b1;
                    n_state = lbs_pkg::ST_IDLE;
                end
            end
            default: n_state = lbs_pkg::ST_IDLE;
        endcase
    end
endmodule

### hdl/linear_blend_vertex_skinning.sv
// ============================================================================
// linear_blend_vertex_skinning: four-bone linear blend skinning engine
// Palette writes, per-vertex transform, weight blend and batch flagging.
// ============================================================================
// A palette write transfer is accepted back to back while no vertex is in
// progress. A vertex transfer runs its blended bones in turn: each bone needs
// twelve reads of the palette memory feeding one shared multiplier pair, a
// step to finish the last product and a weight step; one bone mode and two
// bone mode with equal indices take one bone. The result sits in an output
// register, so the next item is accepted while it waits; a vertex finishing
// while an earlier result still waits stalls until that result is taken.
// No clearing pass is needed after reset.
module linear_blend_vertex_skinning #(
    parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: entry_address, entry_value, bone_indices, weights, pos_x, pos_y,
    // pos_z, norm_x, norm_y, norm_z, tex_coords, zero pad to 384 bits
    input  logic [383:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y,
    // out_norm_z, out_tex_coords
    output logic [255:0] m_axis_tdata,
    output logic         m_axis_tlast,   // batch_done
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    logic [2:0]  r_infl;
    logic [15:0] r_vcount, r_vcnt;
    logic        r_ovalid, r_last;

    logic          w_busy, w_done, w_start, w_acc;
    lbs_pkg::t_cmd w_cmd;
    logic [2:0]    w_mode;
    logic signed [31:0] w_pos [3], w_norm [3], w_opos [3], w_onorm [3];
    logic [63:0]   w_tex;

    assign s_axis_tready = !w_busy;
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_start = w_acc && (s_axis_tuser == lbs_pkg::FUNC_VERTEX);

    // Effective bone count
    always_comb begin
        logic [2:0] n;
        n = (r_infl == 3'd0) ? 3'd1 : (r_infl > 3'd4) ? 3'd4 : r_infl;
        if (n == 3'd2 && s_axis_tdata[51:44] == s_axis_tdata[59:52] && w_start) begin
            n = 3'd1;
        end
        w_mode = n;
    end

    // Hold the mode of the vertex in flight
    logic [2:0] r_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 3'd1;
        end else if (w_start) begin
            r_mode <= w_mode;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_unpack
        assign w_pos[k]  = s_axis_tdata[124 + 32*k +: 32];
        assign w_norm[k] = s_axis_tdata[220 + 32*k +: 32];
    end

    lbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_mode     (w_start ? w_mode : r_mode),
        .i_out_free (!r_ovalid || m_axis_tready),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy),
        .o_done     (w_done)
    );

    lbs_datapath #(.MAX_BONES(MAX_BONES)) u_dp (
        .i_clk          (i_clk),
        .i_wr_en        (w_acc && (s_axis_tuser == lbs_pkg::FUNC_WRITE)),
        .i_wr_addr      (s_axis_tdata[11:0]),
        .i_wr_data      (s_axis_tdata[43:12]),
        .i_cmd          (w_cmd),
        .i_mode         (w_start ? w_mode : r_mode),
        .i_bone_indices (s_axis_tdata[75:44]),
        .i_weights      (s_axis_tdata[123:76]),
        .i_pos          (w_pos),
        .i_norm         (w_norm),
        .i_tex          (s_axis_tdata[379:316]),
        .o_pos          (w_opos),
        .o_norm         (w_onorm),
        .o_tex          (w_tex)
    );

    // Configuration, batch counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_infl   <= 3'd1;
            r_vcount <= 16'd1;
            r_vcnt   <= '0;
            r_ovalid <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lbs_pkg::REG_INFLUENCE: r_infl   <= i_cfg_data[2:0];
                    default:                r_vcount <= i_cfg_data;
                endcase
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
                if (17'(r_vcnt) + 17'd1 >= 17'(r_vcount) || r_vcount == 16'd0) begin
                    r_last <= 1'b1;
                    r_vcnt <= '0;
                end else begin
                    r_last <= 1'b0;
                    r_vcnt <= r_vcnt + 16'd1;
                end
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {w_tex, w_onorm[2], w_onorm[1], w_onorm[0],
                            w_opos[2], w_opos[1], w_opos[0]};

    // Result can only appear once a vertex ran
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_busy) else $error("result without vertex");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready) else $error("accepted while busy");
    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && r_vcount != 16'd0 |=> r_vcnt < r_vcount || r_vcnt == 16'd0)
        else $error("batch counter out of range");
endmodule
